// File: hdl/rle_mono_bitmap_expander_assert.svh
// Assertion macros shared by the bitmap expander RTL.
`ifndef RLE_MONO_BITMAP_EXPANDER_ASSERT_SVH
`define RLE_MONO_BITMAP_EXPANDER_ASSERT_SVH

// Check that cond_a implies cond_c at the same clock edge.
`define RMBE_ASSERT_SAME(label, clk, rstn, cond_a, cond_c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond_a) |-> (cond_c)) \
        else $error("rmbe: same-cycle check failed");

// Check that cond_a implies cond_c at the next clock edge.
`define RMBE_ASSERT_NEXT(label, clk, rstn, cond_a, cond_c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond_a) |=> (cond_c)) \
        else $error("rmbe: next-cycle check failed");

`endif

// File: hdl/rmbe_pkg.sv
// Shared constants for the run-length coded bitmap expander.
package rmbe_pkg;

    // Image dimension width and derived counter widths
    localparam int DIM_BITS     = 12;
    localparam int AREA_BITS    = 2 * DIM_BITS;

    // Pixel geometry
    localparam int PIX_PER_BYTE = 8;
    localparam int PIX_PER_WORD = 2 * PIX_PER_BYTE;
    localparam int COLOR_BITS   = 16;
    localparam int CNT_BITS     = $clog2(PIX_PER_WORD + 1);
    localparam int NUM_BITS     = $clog2(PIX_PER_BYTE + 1);

    // Header byte above this value opens a literal run
    localparam logic [7:0] LIT_BASE = 8'd128;

    // Configuration register indexes
    localparam logic [1:0] REG_FG_COLOR     = 2'd0;
    localparam logic [1:0] REG_BG_COLOR     = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    // Reset values of the configuration registers
    localparam logic [COLOR_BITS-1:0] FG_RESET     = 16'hFFFF;
    localparam logic [COLOR_BITS-1:0] BG_RESET     = 16'h0000;
    localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(240);
    localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(320);

endpackage

// File: hdl/rle_mono_bitmap_expander.sv
// Top level: run-length coded 1-bit bitmap to RGB565 pixel expander.
//
// Code bytes are accepted only while the sequencer is idle. A header byte and a
// zero-count repeat give no word and finish in their accept cycle. A literal byte
// makes one pass through the expansion unit, which produces one output word. A repeat
// byte with count N is expanded N times by the single expansion unit, once per cycle
// while the output is not stalled, and two expansions are packed into each output word
// (ceil(N/2) words). The input is not ready while a byte is being expanded, and
// a finished word waits on a full output register. Pixel colors are applied from
// fg_color/bg_color at the output register, so configuration must only change while idle.
`include "rle_mono_bitmap_expander_assert.svh"

module rle_mono_bitmap_expander (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Compressed stream in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_code_byte,
    input  logic        s_image_start,
    // Pixel words out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_pixels_0_3,
    output logic [63:0] m_pixels_4_7,
    output logic [63:0] m_pixels_8_11,
    output logic [63:0] m_pixels_12_15,
    output logic [4:0]  m_pixel_count,
    output logic        m_last_of_item
);

    localparam int DW = rmbe_pkg::DIM_BITS;
    localparam int AW = rmbe_pkg::AREA_BITS;
    localparam int PW = rmbe_pkg::PIX_PER_WORD;
    localparam int CW = rmbe_pkg::COLOR_BITS;
    localparam int KW = rmbe_pkg::CNT_BITS;
    localparam int NW = rmbe_pkg::NUM_BITS;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } phase_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_EXPAND
    } seq_t;

    // Configuration registers
    logic [CW-1:0] fg_reg, bg_reg;
    logic [DW-1:0] width_reg, height_reg;

    // Decoder state
    seq_t          seq_reg, seq_next;
    phase_t        phase_reg, phase_next;
    logic [6:0]    lit_left_reg, lit_left_next;
    logic [7:0]    rep_cnt_reg, rep_cnt_next;
    logic [DW-1:0] row_left_reg, row_left_next;
    logic [AW-1:0] img_left_reg, img_left_next;
    logic          done_reg, done_next;

    // Expansion working registers
    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    exp_left_reg, exp_left_next;
    logic [PW-1:0] acc_mask_reg, acc_mask_next;
    logic [KW-1:0] acc_cnt_reg, acc_cnt_next;
    logic          half_reg, half_next;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic [PW-1:0] m_mask_reg, m_mask_next;
    logic [KW-1:0] m_cnt_reg, m_cnt_next;
    logic          m_last_reg, m_last_next;

    // Start-of-image view of the state
    logic [AW-1:0] area;
    phase_t        eff_phase;
    logic [AW-1:0] eff_img_left;
    logic          eff_done;

    // Shared expansion unit
    logic [DW-1:0] row_eff;
    logic [NW-1:0] exp_n;
    logic [7:0]    byte_kept;
    logic [PW-1:0] placed;
    logic [PW-1:0] new_mask;
    logic [KW-1:0] new_cnt;
    logic [AW-1:0] n_wide;
    logic          word_done;
    logic          word_last;
    logic          out_free;
    logic          step;

    logic [4*64-1:0] pix_all;

    assign area         = AW'(width_reg) * AW'(height_reg);
    assign eff_phase    = s_image_start ? PH_HEADER : phase_reg;
    assign eff_img_left = s_image_start ? area : img_left_reg;
    assign eff_done     = s_image_start ? 1'b0 : done_reg;

    // Expand one copy of the held byte at the current fill position
    assign row_eff   = (row_left_reg == '0) ? width_reg : row_left_reg;
    assign exp_n     = (row_eff < DW'(rmbe_pkg::PIX_PER_BYTE)) ? NW'(row_eff)
                                                               : NW'(rmbe_pkg::PIX_PER_BYTE);
    assign byte_kept = byte_reg & ~(8'hFF >> exp_n);
    assign placed    = {byte_kept, 8'h00} >> acc_cnt_reg;
    assign new_mask  = acc_mask_reg | placed;
    assign new_cnt   = acc_cnt_reg + KW'(exp_n);
    assign n_wide    = AW'(exp_n);
    assign word_last = (exp_left_reg == 8'd1);
    assign word_done = half_reg || word_last;
    assign out_free  = !m_valid_reg || m_ready;
    assign step      = !word_done || out_free;

    assign s_ready = (seq_reg == SEQ_IDLE);

    // Next-state logic for the sequencer and decoder
    always_comb begin
        seq_next      = seq_reg;
        phase_next    = phase_reg;
        lit_left_next = lit_left_reg;
        rep_cnt_next  = rep_cnt_reg;
        row_left_next = row_left_reg;
        img_left_next = img_left_reg;
        done_next     = done_reg;
        byte_next     = byte_reg;
        exp_left_next = exp_left_reg;
        acc_mask_next = acc_mask_reg;
        acc_cnt_next  = acc_cnt_reg;
        half_next     = half_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_mask_next   = m_mask_reg;
        m_cnt_next    = m_cnt_reg;
        m_last_next   = m_last_reg;

        unique case (seq_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    // A start byte abandons any open run and reloads the image
                    if (s_image_start) begin
                        img_left_next = area;
                        row_left_next = '0;
                        lit_left_next = '0;
                        rep_cnt_next  = '0;
                        phase_next    = PH_HEADER;
                        done_next     = 1'b0;
                    end
                    if (!eff_done) begin
                        unique case (eff_phase)
                            PH_LITERAL: begin
                                byte_next     = s_code_byte;
                                exp_left_next = 8'd1;
                                acc_mask_next = '0;
                                acc_cnt_next  = '0;
                                half_next     = 1'b0;
                                seq_next      = SEQ_EXPAND;
                                lit_left_next = lit_left_reg - 7'd1;
                                if (lit_left_reg == 7'd1) begin
                                    phase_next = PH_HEADER;
                                end
                            end
                            PH_REPEAT: begin
                                phase_next   = PH_HEADER;
                                rep_cnt_next = '0;
                                if (rep_cnt_reg != '0) begin
                                    byte_next     = s_code_byte;
                                    exp_left_next = rep_cnt_reg;
                                    acc_mask_next = '0;
                                    acc_cnt_next  = '0;
                                    half_next     = 1'b0;
                                    seq_next      = SEQ_EXPAND;
                                end
                            end
                            default: begin
                                // Header: stop once the image is complete
                                phase_next = PH_HEADER;
                                if (eff_img_left == '0) begin
                                    done_next = 1'b1;
                                end else if (s_code_byte > rmbe_pkg::LIT_BASE) begin
                                    lit_left_next = s_code_byte[6:0];
                                    phase_next    = PH_LITERAL;
                                end else begin
                                    rep_cnt_next = s_code_byte;
                                    phase_next   = PH_REPEAT;
                                end
                            end
                        endcase
                    end
                end
            end
            SEQ_EXPAND: begin
                // Hold the whole step while a finished word cannot be stored
                if (step) begin
                    row_left_next = row_eff - DW'(exp_n);
                    img_left_next = (img_left_reg > n_wide) ? img_left_reg - n_wide : '0;
                    exp_left_next = exp_left_reg - 8'd1;
                    if (word_done) begin
                        m_valid_next  = 1'b1;
                        m_mask_next   = new_mask;
                        m_cnt_next    = new_cnt;
                        m_last_next   = word_last;
                        acc_mask_next = '0;
                        acc_cnt_next  = '0;
                        half_next     = 1'b0;
                        if (word_last) begin
                            seq_next = SEQ_IDLE;
                        end
                    end else begin
                        acc_mask_next = new_mask;
                        acc_cnt_next  = new_cnt;
                        half_next     = 1'b1;
                    end
                end
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    // State, configuration and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg       <= rmbe_pkg::FG_RESET;
            bg_reg       <= rmbe_pkg::BG_RESET;
            width_reg    <= rmbe_pkg::WIDTH_RESET;
            height_reg   <= rmbe_pkg::HEIGHT_RESET;
            seq_reg      <= SEQ_IDLE;
            phase_reg    <= PH_HEADER;
            lit_left_reg <= '0;
            rep_cnt_reg  <= '0;
            row_left_reg <= '0;
            img_left_reg <= '0;
            done_reg     <= 1'b1;
            exp_left_reg <= '0;
            acc_mask_reg <= '0;
            acc_cnt_reg  <= '0;
            half_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rmbe_pkg::REG_FG_COLOR:     fg_reg     <= cfg_wdata;
                    rmbe_pkg::REG_BG_COLOR:     bg_reg     <= cfg_wdata;
                    rmbe_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[DW-1:0];
                    rmbe_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[DW-1:0];
                    default: ;
                endcase
            end
            seq_reg      <= seq_next;
            phase_reg    <= phase_next;
            lit_left_reg <= lit_left_next;
            rep_cnt_reg  <= rep_cnt_next;
            row_left_reg <= row_left_next;
            img_left_reg <= img_left_next;
            done_reg     <= done_next;
            exp_left_reg <= exp_left_next;
            acc_mask_reg <= acc_mask_next;
            acc_cnt_reg  <= acc_cnt_next;
            half_reg     <= half_next;
            m_valid_reg  <= m_valid_next;
        end
        byte_reg   <= byte_next;
        m_mask_reg <= m_mask_next;
        m_cnt_reg  <= m_cnt_next;
        m_last_reg <= m_last_next;
    end

    // Color the held word; slots past the pixel count read as zero
    always_comb begin
        pix_all = '0;
        for (int i = 0; i < PW; i++) begin
            if (KW'(i) < m_cnt_reg) begin
                pix_all[4*64-1-CW*i -: CW] = m_mask_reg[PW-1-i] ? fg_reg : bg_reg;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixels_0_3   = pix_all[255:192];
    assign m_pixels_4_7   = pix_all[191:128];
    assign m_pixels_8_11  = pix_all[127:64];
    assign m_pixels_12_15 = pix_all[63:0];
    assign m_pixel_count  = m_cnt_reg;
    assign m_last_of_item = m_last_reg;

    // A held word never claims more pixels than it has slots
    `RMBE_ASSERT_SAME(a_cnt_range, aclk, aresetn, m_valid_reg, m_cnt_reg <= KW'(PW))
    // The sequencer only expands while copies remain
    `RMBE_ASSERT_SAME(a_exp_left, aclk, aresetn, seq_reg == SEQ_EXPAND, exp_left_reg != '0)
    // The first half of a word holds at most one byte of pixels
    `RMBE_ASSERT_SAME(a_half_fill, aclk, aresetn, half_reg,
                      acc_cnt_reg <= KW'(rmbe_pkg::PIX_PER_BYTE))
    // A final word returns the sequencer to idle
    `RMBE_ASSERT_NEXT(a_last_idle, aclk, aresetn,
                      seq_reg == SEQ_EXPAND && step && word_last, seq_reg == SEQ_IDLE)

endmodule

// File: sim/rmbe_tb_pkg.sv
// Scoreboard for the bitmap expander: predicts pixel words and checks them.
package rmbe_tb_pkg;
    import rmbe_pkg::*;

    typedef enum logic [1:0] {
        AWAIT_HEADER,
        IN_LITERAL,
        IN_REPEAT
    } decode_state_e;

    // One pixel word: quad[0] holds pixels 0..3, earliest pixel in the top bits
    typedef struct packed {
        logic [3:0][63:0]    quad;
        logic [CNT_BITS-1:0] count;
        logic                last;
    } pixel_word_t;

    class pixel_word_tracker;
        logic [COLOR_BITS-1:0] fg;
        logic [COLOR_BITS-1:0] bg;
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;

        decode_state_e         state;
        logic [6:0]            lit_left;
        logic [7:0]            rep_count;
        logic [DIM_BITS-1:0]   row_left;
        logic [AREA_BITS-1:0]  area_left;
        bit                    image_done;

        pixel_word_t           expected_words[$];
        int                    errors;
        int                    decoded;

        function new();
            fg         = FG_RESET;
            bg         = BG_RESET;
            width      = WIDTH_RESET;
            height     = HEIGHT_RESET;
            state      = AWAIT_HEADER;
            lit_left   = '0;
            rep_count  = '0;
            row_left   = '0;
            area_left  = '0;
            image_done = 1'b1;
            errors     = 0;
            decoded    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_FG_COLOR:     fg = val;
                REG_BG_COLOR:     bg = val;
                REG_IMAGE_WIDTH:  width = val[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: height = val[DIM_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Expand one data byte MSB first, clipped at the end of the row
        function void expand(logic [7:0] b, inout pixel_word_t w);
            int n;
            int k;
            int slot;
            if (row_left == 0)
                row_left = width;
            n = (row_left < 8) ? int'(row_left) : 8;
            for (k = 0; k < n; k++) begin
                slot = w.count[3:0];
                w.quad[slot / 4][48 - 16 * (slot % 4) +: 16] = b[7 - k] ? fg : bg;
                w.count++;
            end
            row_left -= n;
            area_left = (area_left > n) ? area_left - n : '0;
        endfunction

        // Advance the decoder by one accepted byte; return 0 if the byte is dropped
        function bit take_code_byte(logic [7:0] c, logic start);
            pixel_word_t w;
            int total;
            int r;
            if (start) begin
                area_left  = width * height;
                row_left   = '0;
                lit_left   = '0;
                rep_count  = '0;
                state      = AWAIT_HEADER;
                image_done = 1'b0;
            end
            if (image_done)
                return 1'b0;
            decoded++;
            case (state)
                IN_LITERAL: begin
                    w = '0;
                    expand(c, w);
                    w.last = 1'b1;
                    expected_words.push_back(w);
                    lit_left--;
                    if (lit_left == 0)
                        state = AWAIT_HEADER;
                end
                IN_REPEAT: begin
                    // two expansions per word, the last one single on an odd count
                    total = (int'(rep_count) + 1) / 2;
                    for (r = 0; r < total; r++) begin
                        w = '0;
                        expand(c, w);
                        if (2 * r + 1 < int'(rep_count))
                            expand(c, w);
                        w.last = (r == total - 1);
                        expected_words.push_back(w);
                    end
                    rep_count = '0;
                    state = AWAIT_HEADER;
                end
                default: begin
                    state = AWAIT_HEADER;
                    if (area_left == 0) begin
                        image_done = 1'b1;
                    end else if (c > LIT_BASE) begin
                        lit_left = 7'(c - LIT_BASE);
                        state = IN_LITERAL;
                    end else begin
                        rep_count = c;
                        state = IN_REPEAT;
                    end
                end
            endcase
            return 1'b1;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %h, expected %h", what, got, want);
        endtask

        // Compare one accepted word against the oldest prediction
        task check_word(logic [63:0] p0, logic [63:0] p1, logic [63:0] p2,
                        logic [63:0] p3, logic [4:0] cnt, logic last);
            pixel_word_t w;
            if (expected_words.size() == 0) begin
                report("word with none pending, pixel_count", 64'(cnt), '0);
                return;
            end
            w = expected_words.pop_front();
            if (p0 !== w.quad[0])
                report("pixels_0_3", p0, w.quad[0]);
            if (p1 !== w.quad[1])
                report("pixels_4_7", p1, w.quad[1]);
            if (p2 !== w.quad[2])
                report("pixels_8_11", p2, w.quad[2]);
            if (p3 !== w.quad[3])
                report("pixels_12_15", p3, w.quad[3]);
            if (cnt !== w.count)
                report("pixel_count", 64'(cnt), 64'(w.count));
            if (last !== w.last)
                report("last_of_item", 64'(last), 64'(w.last));
        endtask

        function int pending();
            return expected_words.size();
        endfunction
    endclass

endpackage

// File: sim/rle_mono_bitmap_expander_tb.sv
// Testbench top: drives code bytes and config, checks pixel words against the tracker.
module rle_mono_bitmap_expander_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmbe_pkg::*;
    import rmbe_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 32;
    localparam int DIM_MAX       = (1 << DIM_BITS) - 1;
    localparam int SEND_IDLE[4]  = '{0, 75, 0, 17};
    localparam int RECV_STALL[4] = '{0, 0, 75, 17};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_FG_COLOR;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_code_byte = '0;
    logic        s_image_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_pixels_0_3;
    logic [63:0] m_pixels_4_7;
    logic [63:0] m_pixels_8_11;
    logic [63:0] m_pixels_12_15;
    logic [4:0]  m_pixel_count;
    logic        m_last_of_item;

    pixel_word_tracker tracker = new();
    int send_idle_pct = 17;
    int recv_stall_pct = 17;
    int cycle_count = 0;

    rle_mono_bitmap_expander dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .s_image_start  (s_image_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixels_0_3   (m_pixels_0_3),
        .m_pixels_4_7   (m_pixels_4_7),
        .m_pixels_8_11  (m_pixels_8_11),
        .m_pixels_12_15 (m_pixels_12_15),
        .m_pixel_count  (m_pixel_count),
        .m_last_of_item (m_last_of_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Check each accepted word, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_word(m_pixels_0_3, m_pixels_4_7, m_pixels_8_11,
                               m_pixels_12_15, m_pixel_count, m_last_of_item);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words pending", cycle_count,
                 tracker.pending());
        $display("FAIL rle_mono_bitmap_expander");
        $finish;
    end

    // Offer one code byte, hold it until accepted, then idle at random
    task automatic send_byte(logic [7:0] c, logic st);
        s_code_byte   <= c;
        s_image_start <= st;
        s_valid       <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        void'(tracker.take_code_byte(c, st));
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Drain every pending word, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        tracker.write_reg(idx, val);
    endtask

    task automatic program_regs(logic [15:0] fg, logic [15:0] bg,
                                logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
        write_reg(REG_FG_COLOR, fg);
        write_reg(REG_BG_COLOR, bg);
        write_reg(REG_IMAGE_WIDTH, 16'(w));
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly short literal and repeat runs; long runs stay rare
    function automatic logic [7:0] pick_header();
        case ($urandom_range(19))
            0:       return 8'($urandom_range(129, 255));
            1:       return 8'($urandom_range(0, 128));
            2:       return ($urandom_range(1) != 0) ? 8'd128 : 8'd0;
            3, 4, 5, 6, 7, 8, 9, 10, 11:
                     return 8'($urandom_range(129, 134));
            default: return 8'($urandom_range(0, 16));
        endcase
    endfunction

    function automatic logic [7:0] pick_data();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_BITS-1:0] pick_dim(int typical_max);
        case ($urandom_range(9))
            0:       return DIM_BITS'(1);
            1:       return DIM_BITS'(DIM_MAX);
            2:       return DIM_BITS'($urandom_range(1, DIM_MAX));
            default: return DIM_BITS'($urandom_range(1, typical_max));
        endcase
    endfunction

    // Well-formed images with random content, plus stray bytes and cut-off runs
    task automatic run_random_phase(int quota);
        int first;
        first = tracker.decoded;
        while (tracker.decoded - first < quota) begin
            if (tracker.image_done) begin
                if ($urandom_range(3) == 0)
                    send_byte(8'($urandom), 1'b0);
                else
                    send_byte(pick_header(), 1'b1);
            end else if ($urandom_range(49) == 0) begin
                send_byte(pick_header(), 1'b1);
            end else if (tracker.state == AWAIT_HEADER) begin
                send_byte(pick_header(), 1'b0);
            end else begin
                send_byte(pick_data(), 1'b0);
            end
        end
    endtask

    initial begin
        int p;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset colors and size: literal, longest repeat, empty repeat, odd repeat
        send_byte(8'h81, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        // Longest literal run, abandoned by a new image
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte(8'h5A, 1'b0);
        settle();

        // 5x2 image: rows end mid-byte, image runs dry, stray byte dropped
        program_regs(16'h0000, 16'hFFFF, DIM_BITS'(5), DIM_BITS'(2));
        send_byte(8'h82, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h81, 1'b0);
        // Repeat run keeps going after the pixel budget is spent
        send_byte(8'h07, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h10, 1'b0);
        settle();

        // Largest and smallest image
        program_regs(16'($urandom), 16'($urandom), DIM_BITS'(DIM_MAX), DIM_BITS'(DIM_MAX));
        send_byte(8'h80, 1'b1);
        send_byte(8'hAA, 1'b0);
        settle();
        program_regs(16'hFFFF, 16'h0000, DIM_BITS'(1), DIM_BITS'(1));
        send_byte(8'h81, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h55, 1'b0);
        settle();

        // Random phases, each with its own setting and idle pattern
        for (p = 0; p < RANDOM_PHASES; p++) begin
            program_regs(16'($urandom), 16'($urandom), pick_dim(24), pick_dim(6));
            send_idle_pct  = SEND_IDLE[p % 4];
            recv_stall_pct = RECV_STALL[p % 4];
            run_random_phase(PHASE_ITEMS);
            settle();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS rle_mono_bitmap_expander");
        else
            $display("FAIL rle_mono_bitmap_expander");
        $finish;
    end

endmodule
